FILE: sv/pst_pkg.sv
package pst_pkg;

    localparam int SLOTS_DEFAULT = 16;

    localparam int CMD_W    = 3;
    localparam int TID_W    = 5;
    localparam int TIME_W   = 32;
    localparam int IN_W     = CMD_W + TID_W + TIME_W;

    localparam int GID_W    = 5;
    localparam int SIDX_W   = 4;
    localparam int STAT_W   = 2;
    localparam int MASK_W   = 16;
    localparam int RES_W    = 1 + GID_W + SIDX_W + STAT_W + TIME_W + MASK_W;
    localparam int OUT_W    = ((RES_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_CREATE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_KILL   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REAP   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

    localparam logic [STAT_W-1:0] STAT_FREE       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RUNNING    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_TERMINATED = 2'd2;

    typedef struct packed {
        logic load_in;
        logic scan;
        logic idsel;
        logic do_create;
        logic rd_match;
        logic report;
        logic do_reap;
        logic tick_start;
        logic tick_step;
        logic tick_finish;
        logic do_clear;
        logic res_ok;
        logic res_zero;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic             free_any;
        logic             found;
        logic             time_ahead;
        logic             sweep_done;
        logic             out_free;
    } ctrl_status_t;

endpackage

FILE: sv/pst_ram.sv
module pst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/pst_ctrl.sv
module pst_ctrl
    import pst_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_accept,
    output logic         in_ready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN     = 3'd1;
    localparam logic [2:0] ST_DISPATCH = 3'd2;
    localparam logic [2:0] ST_READ     = 3'd3;
    localparam logic [2:0] ST_CREATE   = 3'd4;
    localparam logic [2:0] ST_TICK     = 3'd5;
    localparam logic [2:0] ST_OUT      = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan   = 1'b1;
                state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                state_next = ST_OUT;
                unique case (status.op)
                    CMD_CREATE: begin
                        if (status.free_any) begin
                            cmd.idsel  = 1'b1;
                            state_next = ST_CREATE;
                        end else begin
                            cmd.res_zero = 1'b1;
                        end
                    end
                    CMD_KILL, CMD_LOOKUP: begin
                        if (status.found) begin
                            cmd.rd_match = 1'b1;
                            state_next   = ST_READ;
                        end else begin
                            cmd.res_zero = 1'b1;
                        end
                    end
                    CMD_REAP: begin
                        cmd.do_reap = 1'b1;
                    end
                    CMD_TICK: begin
                        if (status.time_ahead) begin
                            cmd.tick_start = 1'b1;
                            state_next     = ST_TICK;
                        end else begin
                            cmd.res_ok = 1'b1;
                        end
                    end
                    CMD_CLEAR: begin
                        cmd.do_clear = 1'b1;
                    end
                    default: begin
                        cmd.res_zero = 1'b1;
                    end
                endcase
            end
            ST_READ: begin
                cmd.report = 1'b1;
                state_next = ST_OUT;
            end
            ST_CREATE: begin
                cmd.do_create = 1'b1;
                state_next    = ST_OUT;
            end
            ST_TICK: begin
                if (status.sweep_done) begin
                    cmd.tick_finish = 1'b1;
                    state_next      = ST_OUT;
                end else begin
                    cmd.tick_step = 1'b1;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/pst_dp.sv
module pst_dp
    import pst_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  ctrl_cmd_t        cmd,
    output ctrl_status_t     status,
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int ID_W   = $clog2(SLOTS + 1);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    logic [ID_W-1:0]   entry_id_reg [SLOTS];
    logic [SLOTS-1:0]  term_reg;
    logic [TIME_W-1:0] prev_time_reg;

    logic [CMD_W-1:0]  op_reg;
    logic [TID_W-1:0]  target_reg;
    logic [TIME_W-1:0] now_reg;

    logic [SLOTS-1:0]  used_reg;
    logic              free_any_reg;
    logic [SLOT_W-1:0] free_idx_reg;
    logic              found_reg;
    logic [SLOT_W-1:0] match_idx_reg;
    logic              match_term_reg;
    logic              time_ahead_reg;
    logic [TIME_W-1:0] delta_reg;
    logic [ID_W-1:0]   new_id_reg;

    logic [CNT_W-1:0]  cnt_reg;
    logic              wr_pend_reg;
    logic [SLOT_W-1:0] wr_idx_reg;

    logic              res_ok_reg;
    logic [GID_W-1:0]  res_id_reg;
    logic [SIDX_W-1:0] res_slot_reg;
    logic [STAT_W-1:0] res_stat_reg;
    logic [TIME_W-1:0] res_run_reg;
    logic [MASK_W-1:0] res_mask_reg;

    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  m_data_reg;

    logic [SLOTS-1:0]  occupied;
    logic [SLOTS-1:0]  running;
    logic [SLOTS-1:0]  match;
    logic [SLOTS-1:0]  reap_mask;
    logic [SLOTS-1:0]  used;
    logic [SLOT_W-1:0] free_idx;
    logic [SLOT_W-1:0] match_idx;
    logic [ID_W-1:0]   new_id;
    logic [ID_W+TID_W-1:0] target_ext;

    logic [GID_W+ID_W-1:0]     new_id_ext;
    logic [SIDX_W+SLOT_W-1:0]  free_idx_ext;
    logic [SIDX_W+SLOT_W-1:0]  match_idx_ext;
    logic [MASK_W+SLOTS-1:0]   reap_mask_ext;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [TIME_W-1:0] ram_wdata;
    logic              ram_re;
    logic [SLOT_W-1:0] ram_raddr;
    logic [TIME_W-1:0] ram_rdata;
    logic [TIME_W:0]   run_sum;
    logic [TIME_W-1:0] run_sat;
    logic              cnt_end;

    always_comb begin
        target_ext = {{ID_W{1'b0}}, target_reg};
        free_idx   = '0;
        match_idx  = '0;
        used       = '0;
        for (int i = 0; i < SLOTS; i++) begin
            occupied[i] = (entry_id_reg[i] != '0);
            match[i]    = (target_reg != '0) &&
                          ({{TID_W{1'b0}}, entry_id_reg[i]} == target_ext);
        end
        running   = occupied & ~term_reg;
        reap_mask = occupied & term_reg;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!occupied[i]) begin
                free_idx = SLOT_W'(i);
            end
            if (match[i]) begin
                match_idx = SLOT_W'(i);
            end
        end
        for (int k = 0; k < SLOTS; k++) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (entry_id_reg[i] == ID_W'(k + 1)) begin
                    used[k] = 1'b1;
                end
            end
        end
        new_id = '0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (!used_reg[k]) begin
                new_id = ID_W'(k + 1);
            end
        end
    end

    assign new_id_ext    = {{GID_W{1'b0}}, new_id_reg};
    assign free_idx_ext  = {{SIDX_W{1'b0}}, free_idx_reg};
    assign match_idx_ext = {{SIDX_W{1'b0}}, match_idx_reg};
    assign reap_mask_ext = {{MASK_W{1'b0}}, reap_mask};

    assign cnt_end = (cnt_reg == CNT_W'(SLOTS));
    assign run_sum = {1'b0, ram_rdata} + {1'b0, delta_reg};
    assign run_sat = run_sum[TIME_W] ? {TIME_W{1'b1}} : run_sum[TIME_W-1:0];

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = wr_idx_reg;
        ram_wdata = run_sat;
        if (cmd.do_create) begin
            ram_we    = 1'b1;
            ram_waddr = free_idx_reg;
            ram_wdata = '0;
        end else if (wr_pend_reg && running[wr_idx_reg]) begin
            ram_we = 1'b1;
        end
        ram_re    = cmd.rd_match || (cmd.tick_step && !cnt_end);
        ram_raddr = cmd.rd_match ? match_idx_reg : cnt_reg[SLOT_W-1:0];
    end

    pst_ram #(
        .WIDTH (TIME_W),
        .DEPTH (SLOTS)
    ) u_run_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                entry_id_reg[i] <= '0;
            end
            term_reg      <= '0;
            prev_time_reg <= '0;
        end else begin
            if (cmd.do_clear) begin
                for (int i = 0; i < SLOTS; i++) begin
                    entry_id_reg[i] <= '0;
                end
                term_reg      <= '0;
                prev_time_reg <= now_reg;
            end
            if (cmd.do_reap) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (reap_mask[i]) begin
                        entry_id_reg[i] <= '0;
                        term_reg[i]     <= 1'b0;
                    end
                end
            end
            if (cmd.do_create) begin
                entry_id_reg[free_idx_reg] <= new_id_reg;
                term_reg[free_idx_reg]     <= 1'b0;
            end
            if (cmd.report && (op_reg == CMD_KILL)) begin
                term_reg[match_idx_reg] <= 1'b1;
            end
            if (cmd.tick_finish) begin
                prev_time_reg <= now_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            wr_pend_reg <= 1'b0;
        end else if (cmd.tick_start) begin
            cnt_reg     <= '0;
            wr_pend_reg <= 1'b0;
        end else if (cmd.tick_step) begin
            wr_pend_reg <= !cnt_end;
            if (!cnt_end) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end else begin
            wr_pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.tick_step) begin
            wr_idx_reg <= cnt_reg[SLOT_W-1:0];
        end
        if (cmd.load_in) begin
            op_reg     <= s_tdata[CMD_W-1:0];
            target_reg <= s_tdata[CMD_W+TID_W-1:CMD_W];
            now_reg    <= s_tdata[IN_W-1:CMD_W+TID_W];
        end
        if (cmd.scan) begin
            used_reg       <= used;
            free_any_reg   <= ~&occupied;
            free_idx_reg   <= free_idx;
            found_reg      <= |match;
            match_idx_reg  <= match_idx;
            match_term_reg <= |(match & term_reg);
            time_ahead_reg <= (now_reg > prev_time_reg);
            delta_reg      <= now_reg - prev_time_reg;
        end
        if (cmd.idsel) begin
            new_id_reg <= new_id;
        end
        if (cmd.res_zero) begin
            res_ok_reg   <= 1'b0;
            res_id_reg   <= '0;
            res_slot_reg <= '0;
            res_stat_reg <= STAT_FREE;
            res_run_reg  <= '0;
            res_mask_reg <= '0;
        end
        if (cmd.res_ok || cmd.tick_finish || cmd.do_clear) begin
            res_ok_reg   <= 1'b1;
            res_id_reg   <= '0;
            res_slot_reg <= '0;
            res_stat_reg <= STAT_FREE;
            res_run_reg  <= '0;
            res_mask_reg <= '0;
        end
        if (cmd.do_reap) begin
            res_ok_reg   <= 1'b1;
            res_id_reg   <= '0;
            res_slot_reg <= '0;
            res_stat_reg <= STAT_FREE;
            res_run_reg  <= '0;
            res_mask_reg <= reap_mask_ext[MASK_W-1:0];
        end
        if (cmd.do_create) begin
            res_ok_reg   <= 1'b1;
            res_id_reg   <= new_id_ext[GID_W-1:0];
            res_slot_reg <= free_idx_ext[SIDX_W-1:0];
            res_stat_reg <= STAT_RUNNING;
            res_run_reg  <= '0;
            res_mask_reg <= '0;
        end
        if (cmd.report) begin
            res_ok_reg   <= 1'b1;
            res_id_reg   <= target_reg;
            res_slot_reg <= match_idx_ext[SIDX_W-1:0];
            res_stat_reg <= ((op_reg == CMD_KILL) || match_term_reg) ?
                            STAT_TERMINATED : STAT_RUNNING;
            res_run_reg  <= ram_rdata;
            res_mask_reg <= '0;
        end
        if (cmd.out_load) begin
            m_data_reg <= {{(OUT_W - RES_W){1'b0}}, res_mask_reg, res_run_reg,
                           res_stat_reg, res_slot_reg, res_id_reg, res_ok_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    assign status.op         = op_reg;
    assign status.free_any   = free_any_reg;
    assign status.found      = found_reg;
    assign status.time_ahead = time_ahead_reg;
    assign status.sweep_done = cnt_end && !wr_pend_reg;
    assign status.out_free   = !m_tvalid_reg || m_tready;

endmodule

FILE: sv/process_slot_table_top.sv
// Process slot table: one command item in, one result item out.
// Input channel s_*: s_tdata carries command, target_id and now_seconds.
// Result channel m_*: m_tdata carries ok, given_id, slot_index, slot_status,
// run_seconds and freed_mask.
// An item is taken while the controller is idle; it is latched, the slot
// table is scanned into registers, then the command executes.
// Create with a free slot, and kill and lookup that find their target,
// pass the scan stage, the id select or run-time RAM read, and the
// output stage. Reap, clear, a tick with no time advance, unused codes
// and misses skip the middle step. A tick with time ahead sweeps the
// run-time RAM one slot per cycle.
// The next item is accepted in the cycle after the result is loaded, even if
// the receiver has not yet taken it; a stalled result holds in the output
// register and blocks only the following result.
// Reset empties the table and zeroes the time base; no clearing pass is
// needed, as a slot's run time is written on create before it is read.
module process_slot_table_top
    import pst_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,  // command[2:0], target_id[7:3], now_seconds[39:8]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata   // ok[0], given_id[5:1], slot_index[9:6],
                                       // slot_status[11:10], run_seconds[43:12],
                                       // freed_mask[59:44], zero[63:60]
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;
    logic         in_ready;

    assign s_tready = in_ready;

    pst_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (s_tvalid && in_ready),
        .in_ready  (in_ready),
        .status    (status),
        .cmd       (cmd)
    );

    pst_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
